>>> src/vdoc_pkg.sv
// ============================================================================
// vdoc_pkg: shared types and constants for the voxel overlap counter
// Holds the item structs, opcodes, register indexes, sequencer states and
// the fixed-point constants of the voxel grid.
// ============================================================================
package vdoc_pkg;

    // Coordinates are signed fixed point in units of 1/256 m.
    localparam int COORD_W = 24;

    // Cell edge of 2.5 m and half of it, in coordinate units.
    localparam int CELL_EDGE = 640;
    localparam int HALF_EDGE = 320;

    // Starting best squared distance, (7.5 m) squared.
    localparam logic [21:0] START_DIST = 22'd3686400;

    localparam logic [15:0] THRESH_RESET = 16'd10;

    // Division by 640 is a shift by 7 and a multiply by the reciprocal of 5.
    localparam int          EDGE_SHIFT  = 7;
    localparam logic [31:0] RECIP5      = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 34;

    localparam int MUL_W = 32;
    localparam int SQ_W  = 21;
    localparam int SUM_W = 23;
    localparam int CFG_INDEX_W = 3;

    localparam logic [1:0] OP_FIRST  = 2'd0;
    localparam logic [1:0] OP_SECOND = 2'd1;
    localparam logic [1:0] OP_FRAME  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_X  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_Y  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_Z  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_X  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_Y  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_Z  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESH = 3'd6;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_AXIS,
        S_TDIV,
        S_BDIV,
        S_REM,
        S_SQ,
        S_SQW,
        S_SRCH,
        S_PICK,
        S_IDX1,
        S_IDX2,
        S_IDX3,
        S_RD,
        S_WB,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } in_item_t;

    typedef struct packed {
        logic [14:0] cells_above;
        logic        grid_overflow;
    } result_t;

endpackage

>>> src/voxel_density_overlap_counter.sv
// ============================================================================
// voxel_density_overlap_counter: two-cloud voxel histogram overlap counter
// Bins points of two clouds into voxel histograms and counts, at end of
// frame, the cells whose counts in both clouds exceed a threshold.
// ============================================================================
// A point item keeps busy high until it is binned or dropped; one shared 32x32
// multiplier under the sequencer does all division, squaring and indexing.
// An end-of-frame item sweeps the histogram memory one cell per cycle and
// strobes its result once the sweep is done.
// After reset the block clears the histogram memory with busy high;
// configuration writes are taken at all times.
module voxel_density_overlap_counter #(
    parameter int CELL_CAPACITY = 16384,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  vdoc_pkg::in_item_t                    point,
    output logic                                  result_valid,
    output vdoc_pkg::result_t                     result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vdoc_pkg::CFG_INDEX_W-1:0]      cfg_addr,
    input  logic [vdoc_pkg::COORD_W-1:0]          cfg_data
);

    localparam int CW = vdoc_pkg::COORD_W;
    localparam int AW = $clog2(CELL_CAPACITY);
    localparam int DW = 2 * COUNT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = {COUNT_WIDTH{1'b1}};

    // Configuration registers. The port is always ready.
    logic signed [CW-1:0] box_min_reg [3];
    logic signed [CW-1:0] box_max_reg [3];
    logic [15:0]          thresh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                box_min_reg[i] <= '0;
                box_max_reg[i] <= '0;
            end
            thresh_reg <= vdoc_pkg::THRESH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                vdoc_pkg::REG_MIN_X:  box_min_reg[0] <= cfg_data;
                vdoc_pkg::REG_MIN_Y:  box_min_reg[1] <= cfg_data;
                vdoc_pkg::REG_MIN_Z:  box_min_reg[2] <= cfg_data;
                vdoc_pkg::REG_MAX_X:  box_max_reg[0] <= cfg_data;
                vdoc_pkg::REG_MAX_Y:  box_max_reg[1] <= cfg_data;
                vdoc_pkg::REG_MAX_Z:  box_max_reg[2] <= cfg_data;
                vdoc_pkg::REG_THRESH: thresh_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    vdoc_pkg::state_t state_reg, state_next;

    logic [1:0]                  op_reg, op_next;
    logic signed [CW-1:0]        pt_reg [3];
    logic signed [CW-1:0]        pt_next [3];
    logic [1:0]                  ax_reg, ax_next;
    logic [1:0]                  k_reg, k_next;
    logic [CW-1:0]               t_reg [3];
    logic [CW-1:0]               t_next [3];
    logic [CW-1:0]               base_reg [3];
    logic [CW-1:0]               base_next [3];
    logic signed [11:0]          r_reg, r_next;
    logic [2:0]                  vld_reg [3];
    logic [2:0]                  vld_next [3];
    logic [vdoc_pkg::SQ_W-1:0]   sq_reg [3][3];
    logic [vdoc_pkg::SQ_W-1:0]   sq_next [3][3];
    logic [1:0]                  dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [21:0]                 best_reg, best_next;
    logic [CW-1:0]               bc_reg [3];
    logic [CW-1:0]               bc_next [3];
    logic                        found_reg, found_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic                        ovf_reg, ovf_next;
    logic [14:0]                 cnt_reg, cnt_next;
    logic [AW:0]                 scan_reg, scan_next;
    logic                        pend_reg, pend_next;
    logic [AW-1:0]               paddr_reg, paddr_next;
    logic                        emit_reg, emit_next;

    // The shared multiplier, registered at its output.
    logic [vdoc_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic [2*vdoc_pkg::MUL_W-1:0] mul_reg;

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
    end

    // Histogram memory, each word holds {second count, first count}.
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] wr_data, rd_data;

    vdoc_hist_mem #(
        .DEPTH (CELL_CAPACITY),
        .WIDTH (DW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vdoc_pkg::S_CLEAR;
            op_reg    <= '0;
            ax_reg    <= '0;
            k_reg     <= '0;
            r_reg     <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            dz_reg    <= '0;
            best_reg  <= '0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            paddr_reg <= '0;
            emit_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pt_reg[i]   <= '0;
                t_reg[i]    <= '0;
                base_reg[i] <= '0;
                vld_reg[i]  <= '0;
                bc_reg[i]   <= '0;
                for (int j = 0; j < 3; j++)
                begin
                    sq_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ax_reg    <= ax_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            dz_reg    <= dz_next;
            best_reg  <= best_next;
            found_reg <= found_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            paddr_reg <= paddr_next;
            emit_reg  <= emit_next;
            pt_reg    <= pt_next;
            t_reg     <= t_next;
            base_reg  <= base_next;
            vld_reg   <= vld_next;
            bc_reg    <= bc_next;
            sq_reg    <= sq_next;
        end
    end

    // Per-axis operands of the current axis.
    logic signed [CW-1:0] p_cur, lo_cur, hi_cur;
    logic signed [CW:0]   span_s;
    logic [CW-1:0]        span_u;
    logic signed [CW+1:0] q_s;
    logic [CW-1:0]        q_u;
    logic [CW+1:0]        base_ext;
    logic signed [CW+1:0] r_full;
    logic [CW-1:0]        tb, bb;
    logic signed [11:0]   diff;
    logic [10:0]          diff_abs;
    logic [vdoc_pkg::SUM_W-1:0] nb_dist;
    logic                 nb_ok;
    logic [2*vdoc_pkg::MUL_W:0] idx_sum;
    logic [COUNT_WIDTH-1:0] cnt_first, cnt_second, cnt_min;

    always_comb
    begin
        p_cur    = pt_reg[ax_reg];
        lo_cur   = box_min_reg[ax_reg];
        hi_cur   = box_max_reg[ax_reg];
        span_s   = (CW+1)'(hi_cur) - (CW+1)'(lo_cur);
        span_u   = span_s[CW-1:0];
        q_s      = (CW+2)'(p_cur) - (CW+2)'(lo_cur) - (CW+2)'(vdoc_pkg::HALF_EDGE);
        q_u      = q_s[CW-1:0];
        tb       = t_reg[ax_reg];
        bb       = base_reg[ax_reg];
        base_ext = {2'b00, bb};
        r_full   = q_s - $signed((base_ext << 9) + (base_ext << 7));

        // Offset k selects neighbor base + k - 1 along the current axis.
        case (k_reg)
            2'd0:    diff = r_reg + 12'sd640;
            2'd2:    diff = r_reg - 12'sd640;
            default: diff = r_reg;
        endcase
        diff_abs = diff[11] ? 11'(-diff) : diff[10:0];

        nb_dist = vdoc_pkg::SUM_W'(sq_reg[0][dx_reg]) + vdoc_pkg::SUM_W'(sq_reg[1][dy_reg])
                + vdoc_pkg::SUM_W'(sq_reg[2][dz_reg]);
        nb_ok   = vld_reg[0][dx_reg] & vld_reg[1][dy_reg] & vld_reg[2][dz_reg];

        idx_sum = {1'b0, mul_reg} + (2*vdoc_pkg::MUL_W+1)'(bc_reg[ax_reg]);

        cnt_first  = rd_data[COUNT_WIDTH-1:0];
        cnt_second = rd_data[DW-1:COUNT_WIDTH];
        cnt_min    = (cnt_first < cnt_second) ? cnt_first : cnt_second;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        pt_next    = pt_reg;
        ax_next    = ax_reg;
        k_next     = k_reg;
        t_next     = t_reg;
        base_next  = base_reg;
        r_next     = r_reg;
        vld_next   = vld_reg;
        sq_next    = sq_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dz_next    = dz_reg;
        best_next  = best_reg;
        bc_next    = bc_reg;
        found_next = found_reg;
        idx_next   = idx_reg;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        scan_next  = scan_reg;
        pend_next  = pend_reg;
        paddr_next = paddr_reg;
        emit_next  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = '0;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        busy       = 1'b1;

        unique case (state_reg)
            vdoc_pkg::S_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_addr   = scan_reg[AW-1:0];
                scan_next = scan_reg + 1'b1;
                if (scan_reg == (AW+1)'(CELL_CAPACITY - 1))
                begin
                    state_next = vdoc_pkg::S_IDLE;
                end
            end

            vdoc_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    op_next    = point.opcode;
                    pt_next[0] = point.point_x;
                    pt_next[1] = point.point_y;
                    pt_next[2] = point.point_z;
                    ax_next    = '0;
                    found_next = 1'b0;
                    best_next  = vdoc_pkg::START_DIST;
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    cnt_next   = '0;
                    case (point.opcode)
                        vdoc_pkg::OP_FIRST, vdoc_pkg::OP_SECOND:
                            state_next = vdoc_pkg::S_AXIS;
                        vdoc_pkg::OP_FRAME:
                            state_next = vdoc_pkg::S_SCAN;
                        default: ;
                    endcase
                end
            end

            // Box check and cell count t = span / 640 along this axis.
            vdoc_pkg::S_AXIS:
            begin
                if (p_cur < lo_cur || p_cur > hi_cur)
                begin
                    state_next = vdoc_pkg::S_IDLE;
                end
                else
                begin
                    mul_a      = vdoc_pkg::MUL_W'(span_u >> vdoc_pkg::EDGE_SHIFT);
                    mul_b      = vdoc_pkg::RECIP5;
                    state_next = vdoc_pkg::S_TDIV;
                end
            end

            // Base cell index, truncated toward zero, so negative offsets give 0.
            vdoc_pkg::S_TDIV:
            begin
                t_next[ax_reg] = mul_reg[vdoc_pkg::RECIP_SHIFT +: CW];
                mul_a          = q_s[CW+1] ? '0
                               : vdoc_pkg::MUL_W'(q_u >> vdoc_pkg::EDGE_SHIFT);
                mul_b          = vdoc_pkg::RECIP5;
                state_next     = vdoc_pkg::S_BDIV;
            end

            vdoc_pkg::S_BDIV:
            begin
                base_next[ax_reg] = mul_reg[vdoc_pkg::RECIP_SHIFT +: CW];
                state_next        = vdoc_pkg::S_REM;
            end

            // Offset from the base centroid and in-range flags of the three
            // neighbors along this axis.
            vdoc_pkg::S_REM:
            begin
                r_next = r_full[11:0];
                vld_next[ax_reg][0] = (bb != '0) && ((CW+1)'(bb) <= (CW+1)'(tb));
                vld_next[ax_reg][1] = (CW+1)'(bb) < (CW+1)'(tb);
                vld_next[ax_reg][2] = ((CW+1)'(bb) + 1'b1) < (CW+1)'(tb);
                k_next     = '0;
                state_next = vdoc_pkg::S_SQ;
            end

            vdoc_pkg::S_SQ:
            begin
                mul_a      = vdoc_pkg::MUL_W'(diff_abs);
                mul_b      = vdoc_pkg::MUL_W'(diff_abs);
                state_next = vdoc_pkg::S_SQW;
            end

            vdoc_pkg::S_SQW:
            begin
                sq_next[ax_reg][k_reg] = mul_reg[vdoc_pkg::SQ_W-1:0];
                if (k_reg == 2'd2)
                begin
                    if (ax_reg == 2'd2)
                    begin
                        dx_next    = '0;
                        dy_next    = '0;
                        dz_next    = '0;
                        state_next = vdoc_pkg::S_SRCH;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 1'b1;
                        state_next = vdoc_pkg::S_AXIS;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = vdoc_pkg::S_SQ;
                end
            end

            // One neighbor per cycle, x outermost and z innermost; only a
            // strictly smaller distance replaces the best so far.
            vdoc_pkg::S_SRCH:
            begin
                if (nb_ok && nb_dist < vdoc_pkg::SUM_W'(best_reg))
                begin
                    best_next  = nb_dist[21:0];
                    found_next = 1'b1;
                    bc_next[0] = base_reg[0] + CW'(dx_reg) - 1'b1;
                    bc_next[1] = base_reg[1] + CW'(dy_reg) - 1'b1;
                    bc_next[2] = base_reg[2] + CW'(dz_reg) - 1'b1;
                end
                if (dz_reg != 2'd2)
                begin
                    dz_next = dz_reg + 1'b1;
                end
                else
                begin
                    dz_next = '0;
                    if (dy_reg != 2'd2)
                    begin
                        dy_next = dy_reg + 1'b1;
                    end
                    else
                    begin
                        dy_next = '0;
                        if (dx_reg != 2'd2)
                        begin
                            dx_next = dx_reg + 1'b1;
                        end
                        else
                        begin
                            state_next = vdoc_pkg::S_PICK;
                        end
                    end
                end
            end

            vdoc_pkg::S_PICK:
            begin
                if (!found_reg)
                begin
                    state_next = vdoc_pkg::S_IDLE;
                end
                else
                begin
                    mul_a      = vdoc_pkg::MUL_W'(bc_reg[2]);
                    mul_b      = vdoc_pkg::MUL_W'(t_reg[1]) + 1'b1;
                    ax_next    = 2'd1;
                    state_next = vdoc_pkg::S_IDX1;
                end
            end

            // z * rows_y + y, then times rows_x plus x, each checked against
            // capacity.
            vdoc_pkg::S_IDX1:
            begin
                if (idx_sum >= (2*vdoc_pkg::MUL_W+1)'(CELL_CAPACITY))
                begin
                    ovf_next   = 1'b1;
                    state_next = vdoc_pkg::S_IDLE;
                end
                else
                begin
                    idx_next   = idx_sum[AW-1:0];
                    ax_next    = 2'd0;
                    state_next = vdoc_pkg::S_IDX2;
                end
            end

            vdoc_pkg::S_IDX2:
            begin
                mul_a      = vdoc_pkg::MUL_W'(idx_reg);
                mul_b      = vdoc_pkg::MUL_W'(t_reg[0]) + 1'b1;
                state_next = vdoc_pkg::S_IDX3;
            end

            vdoc_pkg::S_IDX3:
            begin
                if (idx_sum >= (2*vdoc_pkg::MUL_W+1)'(CELL_CAPACITY))
                begin
                    ovf_next   = 1'b1;
                    state_next = vdoc_pkg::S_IDLE;
                end
                else
                begin
                    idx_next   = idx_sum[AW-1:0];
                    state_next = vdoc_pkg::S_RD;
                end
            end

            vdoc_pkg::S_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = vdoc_pkg::S_WB;
            end

            // Saturating increment of the selected cloud's half of the word.
            vdoc_pkg::S_WB:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if (op_reg == vdoc_pkg::OP_FIRST)
                begin
                    if (cnt_first != COUNT_TOP)
                    begin
                        wr_data[COUNT_WIDTH-1:0] = cnt_first + 1'b1;
                    end
                end
                else if (cnt_second != COUNT_TOP)
                begin
                    wr_data[DW-1:COUNT_WIDTH] = cnt_second + 1'b1;
                end
                state_next = vdoc_pkg::S_IDLE;
            end

            // Read cell i while cell i-1 is counted and cleared.
            vdoc_pkg::S_SCAN:
            begin
                if (scan_reg < (AW+1)'(CELL_CAPACITY))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = scan_reg[AW-1:0];
                    scan_next  = scan_reg + 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = scan_reg[AW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = paddr_reg;
                    if (32'(cnt_min) > 32'(thresh_reg))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                if (scan_reg == (AW+1)'(CELL_CAPACITY) && !pend_reg)
                begin
                    emit_next  = 1'b1;
                    state_next = vdoc_pkg::S_IDLE;
                end
            end

            default: state_next = vdoc_pkg::S_IDLE;
        endcase

        // The overflow flag goes out with the result and starts the next
        // frame clear; the block is idle in the emit cycle.
        if (emit_reg)
        begin
            ovf_next = 1'b0;
        end
    end

    assign result_valid         = emit_reg;
    assign result.cells_above   = cnt_reg;
    assign result.grid_overflow = ovf_reg;

endmodule

>>> src/vdoc_hist_mem.sv
// ============================================================================
// vdoc_hist_mem: histogram storage
// Simple dual-port memory, one write and one registered read per cycle.
// ============================================================================
module vdoc_hist_mem #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
